[rtl/cve_pkg.sv]
// ----------------------------------------------------------------------------
// cve_pkg: shared types and constants for the cellular vortex field block
// Beat formats, CORDIC state carried from cell to cell, register indexes and
// the arctangent table in units of 2^-32 turn.
// ----------------------------------------------------------------------------
package cve_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } cve_pos_t;

  typedef struct packed {
    logic signed [31:0] stream_fn;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] dvx_dx;
    logic signed [31:0] dvy_dx;
    logic signed [31:0] dvx_dy;
    logic signed [31:0] dvy_dy;
  } cve_field_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } cve_rot_t;

  localparam logic [1:0] REG_VELOCITY_AMPLITUDE = 2'd0;
  localparam logic [1:0] REG_STREAM_SCALE       = 2'd1;
  localparam logic [1:0] REG_GRADIENT_SCALE     = 2'd2;
  localparam logic [1:0] REG_TURNS_PER_UNIT     = 2'd3;

  localparam logic signed [31:0] RESET_AMPLITUDE = 32'sd65536;
  localparam logic        [31:0] RESET_TURNS     = 32'd2670177;

  localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [33:0] QUARTER_TURN    = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN       = 34'sd2147483648;
  localparam logic signed [63:0] HALF_LSB30      = 64'sd536870912;

  function automatic logic [31:0] atan_turns(input int step);
    logic [31:0] r;
    case (step)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/cve_cordic_cell.sv]
// ----------------------------------------------------------------------------
// cve_cordic_cell: one rotation-mode CORDIC iteration
// Rotates the incoming vector by the fixed arctangent of its step toward a
// zero residual angle and registers the result for the next cell.
// ----------------------------------------------------------------------------
module cve_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  cve_pkg::cve_rot_t a,
  output cve_pkg::cve_rot_t b
);
  import cve_pkg::*;

  localparam logic signed [33:0] ATAN = $signed({2'b00, atan_turns(STEP)});

  logic signed [33:0] dx;
  logic signed [33:0] dy;

  assign dx = a.y >>> STEP;
  assign dy = a.x >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      b.neg <= a.neg;
      if (!a.z[33]) begin
        b.x <= a.x - dx;
        b.y <= a.y + dy;
        b.z <= a.z - ATAN;
      end else begin
        b.x <= a.x + dx;
        b.y <= a.y - dy;
        b.z <= a.z + ATAN;
      end
    end
  end

endmodule

[rtl/cellular_vortex_field_eval.sv]
// ----------------------------------------------------------------------------
// cellular_vortex_field_eval: cellular vortex flow at one point
// Channel  | valid        | flow control | payload
// pos      | pos_valid    | pos_stall    | pos_beat (pos_x, pos_y)
// res      | res_valid    | res_stall    | res_beat (stream, velocity, gradients)
// cfg      | cfg_valid    | cfg_ready    | cfg_index, cfg_data
// One beat is accepted per cycle while the result side does not stall.
// The pipeline is the phase multiply and fold stages, a row of CORDIC cells, one
// per iteration, then the sign, product, rounding, scaling and output stages.
// Reset restores the register defaults and empties the pipeline.
// A stall on the result side while a result is valid freezes the whole pipeline in the same cycle.
// ----------------------------------------------------------------------------
module cellular_vortex_field_eval #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pos_valid,
  output logic                pos_stall,
  input  cve_pkg::cve_pos_t   pos_beat,
  output logic                res_valid,
  input  logic                res_stall,
  output cve_pkg::cve_field_t res_beat,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import cve_pkg::*;

  logic signed [31:0] velocity_amplitude;
  logic signed [31:0] stream_scale;
  logic signed [31:0] gradient_scale;
  logic        [31:0] turns_per_unit;

  logic adv;
  logic v_phase, v_fold, v_neg, v_trig, v_rnd, v_scl;
  logic [CORDIC_STEPS-1:0] v_cell;

  logic signed [64:0] prod_x, prod_y;
  logic [ANGLE_BITS-1:0] phase_x, phase_y;

  cve_rot_t rot_x [0:CORDIC_STEPS];
  cve_rot_t rot_y [0:CORDIC_STEPS];

  logic signed [31:0] cx, sx, cy, sy;
  logic signed [63:0] p_cc, p_ss, p_cs, p_sc;
  logic signed [33:0] t_cc, t_ss, t_cs, t_sc;
  logic signed [65:0] m_sf, m_vx, m_vy, m_gsc, m_gcs;

  function automatic cve_rot_t fold(input logic [ANGLE_BITS-1:0] ph);
    logic [31:0] ang;
    logic signed [33:0] z;
    cve_rot_t r;
    ang = 32'(ph) << (32 - ANGLE_BITS);
    z = $signed({{2{ang[31]}}, ang});
    r.neg = 1'b0;
    if (z >= QUARTER_TURN) begin
      z = z - HALF_TURN;
      r.neg = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z = z + HALF_TURN;
      r.neg = 1'b1;
    end
    r.x = CORDIC_GAIN_INV;
    r.y = '0;
    r.z = z;
    return r;
  endfunction

  function automatic logic [31:0] rnd_sat(input logic signed [66:0] p);
    logic signed [66:0] r;
    logic [31:0] q;
    r = (p + 67'sd536870912) >>> 30;
    if (r > 67'sd2147483647) begin
      q = 32'h7FFF_FFFF;
    end else if (r < -67'sd2147483648) begin
      q = 32'h8000_0000;
    end else begin
      q = r[31:0];
    end
    return q;
  endfunction

  assign adv       = !res_valid || !res_stall;
  assign pos_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_amplitude <= RESET_AMPLITUDE;
      stream_scale       <= RESET_AMPLITUDE;
      gradient_scale     <= RESET_AMPLITUDE;
      turns_per_unit     <= RESET_TURNS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VELOCITY_AMPLITUDE: velocity_amplitude <= $signed(cfg_data);
        REG_STREAM_SCALE:       stream_scale       <= $signed(cfg_data);
        REG_GRADIENT_SCALE:     gradient_scale     <= $signed(cfg_data);
        REG_TURNS_PER_UNIT:     turns_per_unit     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_phase   <= 1'b0;
      v_fold    <= 1'b0;
      v_cell    <= '0;
      v_neg     <= 1'b0;
      v_trig    <= 1'b0;
      v_rnd     <= 1'b0;
      v_scl     <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v_phase   <= pos_valid;
      v_fold    <= v_phase;
      v_cell    <= {v_cell[CORDIC_STEPS-2:0], v_fold};
      v_neg     <= v_cell[CORDIC_STEPS-1];
      v_trig    <= v_neg;
      v_rnd     <= v_trig;
      v_scl     <= v_rnd;
      res_valid <= v_scl;
    end
  end

  assign prod_x = pos_beat.pos_x * $signed({1'b0, turns_per_unit});
  assign prod_y = pos_beat.pos_y * $signed({1'b0, turns_per_unit});

  always_ff @(posedge clk) begin
    if (adv) begin
      phase_x  <= prod_x[39 -: ANGLE_BITS];
      phase_y  <= prod_y[39 -: ANGLE_BITS];
      rot_x[0] <= fold(phase_x);
      rot_y[0] <= fold(phase_y);
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    cve_cordic_cell #(.STEP(i)) u_cell_x (
      .clk (clk),
      .en  (adv),
      .a   (rot_x[i]),
      .b   (rot_x[i+1])
    );
    cve_cordic_cell #(.STEP(i)) u_cell_y (
      .clk (clk),
      .en  (adv),
      .a   (rot_y[i]),
      .b   (rot_y[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx <= 32'(rot_x[CORDIC_STEPS].neg ? -rot_x[CORDIC_STEPS].x : rot_x[CORDIC_STEPS].x);
      sx <= 32'(rot_x[CORDIC_STEPS].neg ? -rot_x[CORDIC_STEPS].y : rot_x[CORDIC_STEPS].y);
      cy <= 32'(rot_y[CORDIC_STEPS].neg ? -rot_y[CORDIC_STEPS].x : rot_y[CORDIC_STEPS].x);
      sy <= 32'(rot_y[CORDIC_STEPS].neg ? -rot_y[CORDIC_STEPS].y : rot_y[CORDIC_STEPS].y);

      p_cc <= cx * cy;
      p_ss <= sx * sy;
      p_cs <= cx * sy;
      p_sc <= sx * cy;

      t_cc <= 34'((p_cc + HALF_LSB30) >>> 30);
      t_ss <= 34'((p_ss + HALF_LSB30) >>> 30);
      t_cs <= 34'((p_cs + HALF_LSB30) >>> 30);
      t_sc <= 34'((p_sc + HALF_LSB30) >>> 30);

      m_sf  <= stream_scale * t_cs;
      m_vx  <= velocity_amplitude * t_cc;
      m_vy  <= velocity_amplitude * t_ss;
      m_gsc <= gradient_scale * t_sc;
      m_gcs <= gradient_scale * t_cs;

      res_beat.stream_fn <= rnd_sat($signed({m_sf[65], m_sf}));
      res_beat.vel_x     <= rnd_sat($signed({m_vx[65], m_vx}));
      res_beat.vel_y     <= rnd_sat($signed({m_vy[65], m_vy}));
      res_beat.dvx_dx    <= rnd_sat(-$signed({m_gsc[65], m_gsc}));
      res_beat.dvy_dx    <= rnd_sat($signed({m_gcs[65], m_gcs}));
      res_beat.dvx_dy    <= rnd_sat(-$signed({m_gcs[65], m_gcs}));
      res_beat.dvy_dy    <= rnd_sat($signed({m_gsc[65], m_gsc}));
    end
  end

endmodule

[tb/sv/cve_field_checker.sv]
// ----------------------------------------------------------------------------
// cve_field_checker: prediction and scoreboard for cellular_vortex_field_eval
// Watches the position, result and register channels. Every accepted position
// beat is run through a bit-exact predictor: phase scaling, fold, CORDIC,
// rounded trig products and saturated scaling. The prediction is queued, and
// each accepted result beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module cve_field_checker #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pos_valid,
  input  logic                pos_stall,
  input  cve_pkg::cve_pos_t   pos_beat,
  input  logic                res_valid,
  input  logic                res_stall,
  input  cve_pkg::cve_field_t res_beat,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  results_checked
);
  import cve_pkg::*;

  localparam longint GAIN_INV      = 64'sd652032874;
  localparam longint QUARTER       = 64'sd1073741824;
  localparam longint HALF          = 64'sd2147483648;
  localparam longint ROUND_HALF    = 64'sd536870912;
  localparam int     NUM_FIELDS    = 7;
  localparam int     REPORT_LIMIT  = 10;

  longint atan_lut [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  string field_names [NUM_FIELDS] = '{
    "stream_fn", "vel_x", "vel_y", "dvx_dx", "dvy_dx", "dvx_dy", "dvy_dy"
  };

  logic signed [31:0] amp_q;
  logic signed [31:0] stream_q;
  logic signed [31:0] grad_q;
  logic        [31:0] turns_q;

  cve_field_t pending_fields [$];
  int         error_count = 0;
  int         checked = 0;

  function automatic void phase_sin_cos(input logic signed [31:0] pos,
                                        output longint c, output longint s);
    longint                prod;
    longint                z;
    longint                x;
    longint                y;
    longint                dx;
    longint                dy;
    logic [63:0]           prod_bits;
    logic [ANGLE_BITS-1:0] phase;
    logic [31:0]           ang;
    bit                    flip;
    prod      = longint'(pos) * longint'({32'd0, turns_q});
    prod_bits = prod;
    phase     = prod_bits[40-ANGLE_BITS +: ANGLE_BITS];
    ang       = 32'(phase) << (32 - ANGLE_BITS);
    z         = longint'(signed'(ang));
    flip      = 1'b0;
    if (z >= QUARTER) begin
      z    = z - HALF;
      flip = 1'b1;
    end else if (z < -QUARTER) begin
      z    = z + HALF;
      flip = 1'b1;
    end
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_lut[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_lut[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + ROUND_HALF) >>> 30;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647)
      return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648)
      return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic cve_field_t predict_field(input cve_pos_t p);
    longint     cx, sx, cy, sy;
    longint     cc, ss, cs, sc;
    cve_field_t f;
    phase_sin_cos(p.pos_x, cx, sx);
    phase_sin_cos(p.pos_y, cy, sy);
    cc = round_q30(cx * cy);
    ss = round_q30(sx * sy);
    cs = round_q30(cx * sy);
    sc = round_q30(sx * cy);
    f.stream_fn = clamp32(round_q30(longint'(stream_q) * cs));
    f.vel_x     = clamp32(round_q30(longint'(amp_q) * cc));
    f.vel_y     = clamp32(round_q30(longint'(amp_q) * ss));
    f.dvx_dx    = clamp32(round_q30(-(longint'(grad_q) * sc)));
    f.dvy_dx    = clamp32(round_q30(longint'(grad_q) * cs));
    f.dvx_dy    = clamp32(round_q30(-(longint'(grad_q) * cs)));
    f.dvy_dy    = clamp32(round_q30(longint'(grad_q) * sc));
    return f;
  endfunction

  always @(posedge clk) begin
    cve_field_t  want;
    logic [31:0] w;
    logic [31:0] g;
    if (rst) begin
      amp_q    = 32'sd65536;
      stream_q = 32'sd65536;
      grad_q   = 32'sd65536;
      turns_q  = 32'd2670177;
      pending_fields.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VELOCITY_AMPLITUDE: amp_q    = cfg_data;
          REG_STREAM_SCALE:       stream_q = cfg_data;
          REG_GRADIENT_SCALE:     grad_q   = cfg_data;
          REG_TURNS_PER_UNIT:     turns_q  = cfg_data;
          default: ;
        endcase
      end
      if (pos_valid && !pos_stall)
        pending_fields.push_back(predict_field(pos_beat));
      if (res_valid && !res_stall) begin
        if (pending_fields.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("Result beat with nothing expected: %h", res_beat);
        end else begin
          want = pending_fields.pop_front();
          checked++;
          for (int k = 0; k < NUM_FIELDS; k++) begin
            w = want[223 - 32*k -: 32];
            g = res_beat[223 - 32*k -: 32];
            if (w !== g) begin
              error_count++;
              if (error_count <= REPORT_LIMIT)
                $display("Mismatch on %s of result %0d: expected %0d, got %0d",
                         field_names[k], checked, $signed(w), $signed(g));
            end
          end
        end
      end
    end
    mismatches      <= error_count;
    outstanding     <= pending_fields.size();
    results_checked <= checked;
  end

endmodule

[tb/sv/tb_cellular_vortex_field_eval.sv]
// ----------------------------------------------------------------------------
// tb_cellular_vortex_field_eval: top of the cellular vortex field testbench
// Drives position beats and register writes, and stalls the result side at
// random, with one long hold-off that backs up the pipeline. Directed points
// hit the turn boundaries and saturation; random points then run under a set
// of register settings that includes the extremes. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_cellular_vortex_field_eval;
  import cve_pkg::*;

  localparam int CORDIC_STEPS      = 16;
  localparam int ANGLE_BITS        = 20;
  localparam int LATENCY           = CORDIC_STEPS + 7;
  localparam int WATCHDOG_LIMIT    = 2000;
  localparam int HOLD_CYCLES       = 160;
  localparam int NUM_SETTINGS      = 8;
  localparam int ITEMS_PER_SETTING = 200;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        pos_valid = 1'b0;
  cve_pos_t    pos_beat  = '0;
  logic        res_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = REG_VELOCITY_AMPLITUDE;
  logic [31:0] cfg_data  = '0;
  logic        pos_stall;
  logic        res_valid;
  cve_field_t  res_beat;
  logic        cfg_ready;

  int pos_idle_pct = 0;
  int res_idle_pct = 0;
  bit hold_go      = 1'b0;
  bit hold_taken   = 1'b0;
  int hold_left    = 0;
  int idle_cycles  = 0;
  int items_sent   = 0;
  int writes_done  = 0;
  int mismatches;
  int outstanding;
  int results_checked;

  always #4 clk = ~clk;

  cellular_vortex_field_eval #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .pos_valid (pos_valid),
    .pos_stall (pos_stall),
    .pos_beat  (pos_beat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_beat  (res_beat),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cve_field_checker #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .pos_valid       (pos_valid),
    .pos_stall       (pos_stall),
    .pos_beat        (pos_beat),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .res_beat        (res_beat),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_taken) begin
      res_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      hold_taken <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < res_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (pos_valid && !pos_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("No beat moved for %0d cycles, giving up.", WATCHDOG_LIMIT);
      $display("cellular_vortex_field_eval verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_xy(input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(0, 99) < pos_idle_pct) begin
      pos_valid <= 1'b0;
      @(posedge clk);
    end
    pos_valid      <= 1'b1;
    pos_beat.pos_x <= x;
    pos_beat.pos_y <= y;
    @(posedge clk);
    while (pos_stall)
      @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    pos_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    writes_done++;
  endtask

  task automatic configure(input logic [31:0] amp, input logic [31:0] strm,
                           input logic [31:0] grad, input logic [31:0] turns);
    drain();
    write_reg(REG_VELOCITY_AMPLITUDE, amp);
    write_reg(REG_STREAM_SCALE, strm);
    write_reg(REG_GRADIENT_SCALE, grad);
    write_reg(REG_TURNS_PER_UNIT, turns);
    cfg_valid <= 1'b0;
  endtask

  // Mix of full-range values, small positions and points near quarter turns.
  function automatic logic [31:0] rand_coord();
    int unsigned pick;
    logic [31:0] v;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      v = $urandom;
    end else begin
      if (pick < 8)
        v = $urandom_range(0, 32'h0008_0000);
      else
        v = ($urandom_range(0, 65535) << 14) + $urandom_range(0, 2) - 1;
      if ($urandom_range(0, 1))
        v = -v;
    end
    return v;
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst          <= 1'b0;
    pos_idle_pct <= 17;
    res_idle_pct <= 50;

    send_xy(32'h0000_0000, 32'h0000_0000);
    send_xy(32'h7FFF_FFFF, 32'h8000_0000);
    send_xy(32'h8000_0000, 32'h7FFF_FFFF);
    send_xy(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_xy(32'h8000_0000, 32'h8000_0000);
    send_xy(32'h0000_0001, 32'hFFFF_FFFF);
    send_xy(32'hFFFF_FFFF, 32'h0000_0001);

    // One turn per unit, so multiples of 0x4000 sit exactly on quarter turns.
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0100_0000);
    send_xy(32'h0000_0000, 32'h0000_0000);
    send_xy(32'h0000_4000, 32'h0000_3FFF);
    send_xy(-32'sh4000, -32'sh4001);
    send_xy(32'h0000_8000, -32'sh8000);
    send_xy(32'h0001_0000, 32'h0000_2000);
    send_xy(32'h0000_C000, 32'h0000_6000);
    send_xy(-32'sh2000, 32'h7FFF_C000);
    send_xy(32'h0000_BFFF, 32'h0000_4001);
    send_xy(32'h8000_0000, 32'h0000_0000);

    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_xy(32'h0000_4000, 32'h0000_4000);
    send_xy(32'h0000_0000, 32'h7FFF_FFFF);
    send_xy(32'h8000_0000, 32'h0000_0000);
    send_xy(32'hFFFF_FFFF, 32'h8000_0001);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: configure(32'd65536, 32'd65536, 32'd65536, 32'd2670177);
        2: configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        3: configure($urandom_range(0, 1048576), -$urandom_range(0, 1048576),
                     $urandom_range(0, 1048576), $urandom_range(0, 67108864));
        4: configure(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        default: configure($urandom, $urandom, $urandom, $urandom);
      endcase
      if (s == 3) begin
        pos_idle_pct <= 50;
        res_idle_pct <= 17;
      end
      if (s == 6) begin
        pos_idle_pct <= 0;
        res_idle_pct <= 0;
        hold_go      <= 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_SETTING; n++)
        send_xy(rand_coord(), rand_coord());
    end

    drain();
    $display("Checked %0d field results from %0d positions with %0d register writes.",
             results_checked, items_sent, writes_done);
    $display("Run covered turn folding, phase wrap, saturating scales and a %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0)
      $display("cellular_vortex_field_eval verification clean");
    else
      $display("cellular_vortex_field_eval verification failed");
    $finish;
  end

endmodule
